### rtl/address_lease_server_assert.svh
// ----------------------------------------------------------------------------
// Address lease server assertion macros
// Clocked assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_LEASE_SERVER_ASSERT_SVH
`define ADDRESS_LEASE_SERVER_ASSERT_SVH
`ifndef SYNTHESIS
`define ALS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("address_lease_server assertion failed");
`define ALS_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("address_lease_server assertion failed");
`else
`define ALS_ASSERT(lbl, expr)
`define ALS_IMPLY(lbl, ante, cons)
`endif
`endif

### rtl/als_pkg.sv
// ----------------------------------------------------------------------------
// Address lease server package
// Shared types, codes and sizes for the lease cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package als_pkg;

  localparam int unsigned POOL_SIZE_DEF = 256;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LEASE_W = 16;
  localparam int unsigned POOL_W = 9;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_OFFERED  = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;
  localparam logic [1:0] ST_EXPIRED  = 2'd3;

  localparam logic [1:0] OP_DISCOVER = 2'd0;
  localparam logic [1:0] OP_REQUEST  = 2'd1;

  localparam logic [1:0] DST_SELF      = 2'd0;
  localparam logic [1:0] DST_BROADCAST = 2'd1;
  localparam logic [1:0] DST_OTHER     = 2'd2;

  localparam logic [1:0] RPL_OFFER = 2'd0;
  localparam logic [1:0] RPL_ACK   = 2'd1;
  localparam logic [1:0] RPL_NAK   = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DISC = 2'd1;
  localparam logic [1:0] KIND_REQ  = 2'd2;
  localparam logic [1:0] KIND_REL  = 2'd3;

  localparam logic [1:0] CFG_POOL_IN_USE   = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_LEASE = 2'd1;
  localparam logic [1:0] CFG_MAX_LEASE     = 2'd2;
  localparam logic [1:0] CFG_MIN_LEASE     = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TIME_W-1:0] now;
    logic [ADDR_W-1:0] cli;
    logic [ADDR_W-1:0] raddr;
    logic [POOL_W-1:0] pool;
  } msg_t;

  typedef struct packed {
    logic              valid;
    logic              own_f;
    logic [ADDR_W-1:0] own_idx;
    logic              free_f;
    logic [ADDR_W-1:0] free_idx;
    logic              exp_f;
    logic [ADDR_W-1:0] exp_idx;
    logic              ack_f;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] idx;
    logic [1:0]        status;
    logic [ADDR_W-1:0] owner;
    logic [TIME_W-1:0] expiry;
  } wr_t;

endpackage

### rtl/als_cell.sv
// ----------------------------------------------------------------------------
// Lease cell
// Holds one pool entry; ages it and scores it as the search token passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module als_cell #(
  parameter logic [15:0] CELL_IDX = 16'd0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  als_pkg::msg_t msg,
  input  als_pkg::tok_t tok_in,
  input  als_pkg::wr_t  wr,
  output als_pkg::tok_t tok_out
);
  import als_pkg::*;

  logic [1:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] owner_r;
  logic [TIME_W-1:0] expiry_r, expiry_nxt;
  tok_t              tok_r, tok_nxt;
  logic              served, mine, addr_hit, wr_hit;
  logic [1:0]        st_aged;

  assign served   = {1'b0, CELL_IDX} < {{(ADDR_W+1-POOL_W){1'b0}}, msg.pool};
  assign mine     = (owner_r == msg.cli);
  assign addr_hit = ({1'b0, CELL_IDX} + 17'd1) == {1'b0, msg.raddr};
  assign wr_hit   = wr.en && (wr.idx == CELL_IDX);

  always_comb begin
    status_nxt = status_r;
    expiry_nxt = expiry_r;
    tok_nxt    = tok_in;
    st_aged    = status_r;
    if (tok_in.valid && served) begin
      if (expiry_r <= msg.now) begin
        if (status_r == ST_OFFERED) begin
          st_aged    = ST_FREE;
          expiry_nxt = '0;
        end else if (status_r == ST_OCCUPIED) begin
          st_aged    = ST_EXPIRED;
          expiry_nxt = '0;
        end
      end
      status_nxt = st_aged;
      if (msg.kind == KIND_REL && st_aged == ST_OFFERED && mine) begin
        status_nxt = ST_FREE;
        expiry_nxt = '0;
      end
      if (!tok_in.own_f && st_aged != ST_FREE && mine) begin
        tok_nxt.own_f   = 1'b1;
        tok_nxt.own_idx = CELL_IDX;
      end
      if (!tok_in.free_f && st_aged == ST_FREE) begin
        tok_nxt.free_f   = 1'b1;
        tok_nxt.free_idx = CELL_IDX;
      end
      if (!tok_in.exp_f && st_aged == ST_EXPIRED) begin
        tok_nxt.exp_f   = 1'b1;
        tok_nxt.exp_idx = CELL_IDX;
      end
      if (addr_hit && st_aged != ST_FREE && mine) begin
        tok_nxt.ack_f = 1'b1;
      end
    end
    if (wr_hit) begin
      status_nxt = wr.status;
      expiry_nxt = wr.expiry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_FREE;
      expiry_r <= '0;
      tok_r    <= '0;
    end else begin
      status_r <= status_nxt;
      expiry_r <= expiry_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      owner_r <= wr.owner;
    end
  end

  assign tok_out = tok_r;

endmodule

### rtl/address_lease_server.sv
// ----------------------------------------------------------------------------
// Address lease server
// Lease allocator over a pool of addresses kept in a chain of entry cells.
// ----------------------------------------------------------------------------
// Input channel (in_*): one message per transfer. Result channel (out_*):
// zero or one reply per message (offer, ACK or NAK). Config port (cfg_*):
// write pool_in_use, default_lease, max_lease, min_lease while idle.
// A message launches a search token down the chain of POOL_SIZE cells, one
// cell per cycle; each cell ages its entry, applies releases and scores
// itself as a candidate. The controller then writes the chosen entry and
// loads the reply register. One message is in flight at a time: a new
// message is taken only once the last one has left the write step.
// A waiting reply does not block the next message; only a new reply holds
// in the write step until the receiver takes the old one.
// Reset (synchronous, rst_n low) frees every entry, zeroes expiry times and
// loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module address_lease_server #(
  parameter int unsigned POOL_SIZE = als_pkg::POOL_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_destination,
  input  logic [31:0] in_now_time,
  input  logic [15:0] in_client_id,
  input  logic [15:0] in_requested_address,
  input  logic [31:0] in_requested_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_reply_kind,
  output logic [15:0] out_reply_client,
  output logic [15:0] out_reply_address,
  output logic [31:0] out_reply_expiry,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import als_pkg::*;

  `include "address_lease_server_assert.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PASS  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  msg_t               msg_r;
  logic [TIME_W-1:0]  rend_r, lease_r, lease_nxt;
  logic               start_r;
  tok_t               res_r;
  logic [POOL_W-1:0]  pool_r;
  logic [LEASE_W-1:0] def_r, max_r, min_r;
  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [ADDR_W-1:0]  out_client_r, out_addr_r;
  logic [TIME_W-1:0]  out_expiry_r;
  tok_t               tok_w [POOL_SIZE+1];
  tok_t               tok_start;
  wr_t                wr_c;
  msg_t               msg_c;
  logic               in_xfer, out_free, have_rpl;
  logic [1:0]         rpl_kind;
  logic [ADDR_W-1:0]  rpl_addr;
  logic [TIME_W-1:0]  rpl_exp;
  logic [1:0]         kind_in;
  logic [TIME_W:0]    diff, s_def, s_min, s_max;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    kind_in = KIND_NONE;
    if (in_operation == OP_DISCOVER && in_destination == DST_BROADCAST) begin
      kind_in = KIND_DISC;
    end else if (in_operation == OP_REQUEST && in_destination == DST_SELF) begin
      kind_in = KIND_REQ;
    end else if (in_operation == OP_REQUEST && in_destination == DST_OTHER) begin
      kind_in = KIND_REL;
    end
  end

  always_comb begin
    msg_c      = msg_r;
    msg_c.pool = pool_r;
  end

  always_comb begin
    tok_start       = '0;
    tok_start.valid = start_r;
  end

  assign tok_w[0] = tok_start;

  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    als_cell #(
      .CELL_IDX(16'(i))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .msg    (msg_c),
      .tok_in (tok_w[i]),
      .wr     (wr_c),
      .tok_out(tok_w[i+1])
    );
  end

  assign diff  = {1'b0, rend_r} - {1'b0, msg_r.now};
  assign s_def = {1'b0, msg_r.now} + {{(TIME_W+1-LEASE_W){1'b0}}, def_r};
  assign s_min = {1'b0, msg_r.now} + {{(TIME_W+1-LEASE_W){1'b0}}, min_r};
  assign s_max = {1'b0, msg_r.now} + {{(TIME_W+1-LEASE_W){1'b0}}, max_r};

  always_comb begin
    if (rend_r == '0) begin
      lease_nxt = s_def[TIME_W] ? '1 : s_def[TIME_W-1:0];
    end else if ($signed(diff) < $signed({{(TIME_W+1-LEASE_W){1'b0}}, min_r})) begin
      lease_nxt = s_min[TIME_W] ? '1 : s_min[TIME_W-1:0];
    end else if ($signed(diff) > $signed({{(TIME_W+1-LEASE_W){1'b0}}, max_r})) begin
      lease_nxt = s_max[TIME_W] ? '1 : s_max[TIME_W-1:0];
    end else begin
      lease_nxt = rend_r;
    end
  end

  always_comb begin
    wr_c     = '0;
    have_rpl = 1'b0;
    rpl_kind = RPL_NAK;
    rpl_addr = msg_r.raddr;
    rpl_exp  = '0;
    wr_c.owner  = msg_r.cli;
    wr_c.expiry = lease_r;
    if (msg_r.kind == KIND_DISC) begin
      wr_c.status = ST_OFFERED;
      rpl_kind    = RPL_OFFER;
      rpl_exp     = lease_r;
      if (res_r.own_f) begin
        have_rpl = 1'b1;
        wr_c.idx = res_r.own_idx;
      end else if (res_r.free_f) begin
        have_rpl = 1'b1;
        wr_c.idx = res_r.free_idx;
      end else if (res_r.exp_f) begin
        have_rpl = 1'b1;
        wr_c.idx = res_r.exp_idx;
      end
      rpl_addr = wr_c.idx + 16'd1;
      wr_c.en  = have_rpl;
    end else if (msg_r.kind == KIND_REQ) begin
      have_rpl    = 1'b1;
      wr_c.status = ST_OCCUPIED;
      wr_c.idx    = msg_r.raddr - 16'd1;
      if (res_r.ack_f) begin
        rpl_kind = RPL_ACK;
        rpl_exp  = lease_r;
        wr_c.en  = 1'b1;
      end
    end
    if (state_r != S_WRITE || (have_rpl && !out_free)) begin
      wr_c.en = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_PASS;
      S_PASS:  if (tok_w[POOL_SIZE].valid) state_nxt = S_WRITE;
      S_WRITE: if (!have_rpl || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pool_r      <= POOL_W'(256);
      def_r       <= LEASE_W'(3600);
      max_r       <= LEASE_W'(7200);
      min_r       <= LEASE_W'(60);
    end else begin
      state_r <= state_nxt;
      start_r <= in_xfer;
      if (state_r == S_WRITE && have_rpl && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_POOL_IN_USE:   pool_r <= cfg_wdata[POOL_W-1:0];
          CFG_DEFAULT_LEASE: def_r  <= cfg_wdata;
          CFG_MAX_LEASE:     max_r  <= cfg_wdata;
          CFG_MIN_LEASE:     min_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      msg_r.kind  <= kind_in;
      msg_r.now   <= in_now_time;
      msg_r.cli   <= in_client_id;
      msg_r.raddr <= in_requested_address;
      msg_r.pool  <= pool_r;
      rend_r      <= in_requested_end;
    end
    lease_r <= lease_nxt;
    if (state_r == S_PASS && tok_w[POOL_SIZE].valid) begin
      res_r <= tok_w[POOL_SIZE];
    end
    if (state_r == S_WRITE && have_rpl && out_free) begin
      out_kind_r   <= rpl_kind;
      out_client_r <= msg_r.cli;
      out_addr_r   <= rpl_addr;
      out_expiry_r <= rpl_exp;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reply_kind    = out_kind_r;
  assign out_reply_client  = out_client_r;
  assign out_reply_address = out_addr_r;
  assign out_reply_expiry  = out_expiry_r;

  `ALS_IMPLY(a_wr_only_in_write, wr_c.en, state_r == S_WRITE)
  `ALS_IMPLY(a_wr_idx_in_pool, wr_c.en, {16'd0, wr_c.idx} < 32'(POOL_SIZE))
  `ALS_IMPLY(a_start_after_xfer, start_r, $past(in_xfer))
  `ALS_IMPLY(a_tok_end_in_pass, tok_w[POOL_SIZE].valid, state_r == S_PASS)

endmodule
